/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked on aclk, disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define PFS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PFS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/pfs_pkg.sv */
// ----------------------------------------------------------------------------
// pfs_pkg
// Widths, constants and types of the prime factor stream core.
// ----------------------------------------------------------------------------
package pfs_pkg;

    localparam int VALUE_WIDTH = 31;
    localparam int DIV_WIDTH   = VALUE_WIDTH / 2 + 2;
    localparam int SQ_WIDTH    = 2 * DIV_WIDTH;
    localparam int MAX_RESULTS = 30;
    localparam int CNT_WIDTH   = $clog2(MAX_RESULTS + 1);
    localparam int STEP_WIDTH  = $clog2(VALUE_WIDTH + 1);

    localparam logic [DIV_WIDTH-1:0] DIVISOR_TWO    = DIV_WIDTH'(2);
    localparam logic [DIV_WIDTH-1:0] DIVISOR_THREE  = DIV_WIDTH'(3);
    localparam logic [DIV_WIDTH-1:0] FIRST_WHEEL    = DIV_WIDTH'(5);
    localparam logic [SQ_WIDTH-1:0]  FIRST_WHEEL_SQ = SQ_WIDTH'(25);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_CHECK,
        ST_TEST
    } state_t;

    typedef enum logic [1:0] {
        DC_TWO,
        DC_THREE,
        DC_LOW,
        DC_HIGH
    } div_class_t;

endpackage

/* sv/pfs_div.sv */
// ----------------------------------------------------------------------------
// pfs_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pfs_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [pfs_pkg::VALUE_WIDTH-1:0] dividend,
    input  logic [pfs_pkg::DIV_WIDTH-1:0]   divisor,
    output logic                           done,
    output logic [pfs_pkg::VALUE_WIDTH-1:0] quotient,
    output logic [pfs_pkg::DIV_WIDTH-1:0]   remainder
);

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [pfs_pkg::STEP_WIDTH-1:0]  step_reg, step_next;
    logic [pfs_pkg::DIV_WIDTH-1:0]   rem_reg, rem_next;
    logic [pfs_pkg::VALUE_WIDTH-1:0] quo_reg, quo_next;
    logic [pfs_pkg::DIV_WIDTH-1:0]   dvs_reg, dvs_next;

    logic [pfs_pkg::DIV_WIDTH:0]     shifted;
    logic [pfs_pkg::DIV_WIDTH:0]     diff;
    logic                            fits;

    assign shifted = {rem_reg, quo_reg[pfs_pkg::VALUE_WIDTH-1]};
    assign fits    = shifted >= {1'b0, dvs_reg};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = pfs_pkg::STEP_WIDTH'(pfs_pkg::VALUE_WIDTH);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            rem_next  = fits ? diff[pfs_pkg::DIV_WIDTH-1:0]
                             : shifted[pfs_pkg::DIV_WIDTH-1:0];
            quo_next  = {quo_reg[pfs_pkg::VALUE_WIDTH-2:0], fits};
            step_next = step_reg - pfs_pkg::STEP_WIDTH'(1);
            if (step_reg == pfs_pkg::STEP_WIDTH'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

/* sv/prime_factor_stream_core.sv */
// ----------------------------------------------------------------------------
// prime_factor_stream_core
// Trial-division prime factorizer over a 6k+-1 wheel, one shared divider.
// ----------------------------------------------------------------------------
// Input channel s_valid/s_ready/s_value takes one 31-bit number per
// transaction. The output channel m_valid/m_ready/m_factor/m_last returns
// its prime factors in ascending order, one per transaction, repeated per
// multiplicity; m_last marks the final factor of a run. Inputs 0 and 1
// give no output.
// s_ready is high only while the sequencer is idle. Every trial divisor
// costs one pass of the serial divider (issue, the quotient bits, done,
// check); after 3 and after every 6k+1 divisor a test step compares the
// squared divisor against the value. m_valid rises no earlier than the
// check step of the first trial divisor. A large prime near 2^31 tries
// about 15450 divisors before s_ready returns.
// Results sit in an output register; a stalled receiver holds the
// sequencer in its check or test step until the register frees up, and
// a run's final factor does not block the next input transaction.
// Synchronous active-low reset returns the sequencer to idle and drops
// m_valid; no work survives reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module prime_factor_stream_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [pfs_pkg::VALUE_WIDTH-1:0] s_value,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [pfs_pkg::VALUE_WIDTH-1:0] m_factor,
    output logic                            m_last
);

    pfs_pkg::state_t                 state_reg, state_next;
    pfs_pkg::div_class_t             cls_reg, cls_next;
    logic [pfs_pkg::VALUE_WIDTH-1:0] n_reg, n_next;
    logic [pfs_pkg::DIV_WIDTH-1:0]   d_reg, d_next;
    logic [pfs_pkg::SQ_WIDTH-1:0]    sq_reg, sq_next;
    logic [pfs_pkg::CNT_WIDTH-1:0]   cnt_reg, cnt_next;
    logic                            m_valid_reg, m_valid_next;
    logic [pfs_pkg::VALUE_WIDTH-1:0] m_factor_reg, m_factor_next;
    logic                            m_last_reg, m_last_next;

    logic                            div_start;
    logic                            div_done;
    logic [pfs_pkg::VALUE_WIDTH-1:0] div_quo;
    logic [pfs_pkg::DIV_WIDTH-1:0]   div_rem;

    logic                            accept;
    logic                            out_free;
    logic                            div_hit;
    logic                            hit_last;
    logic                            in_bound;
    logic                            tail_prime;
    logic                            load_hit;
    logic                            load_tail;

    pfs_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (n_reg),
        .divisor   (d_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign accept     = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign div_hit    = (div_rem == '0);
    assign hit_last   = (div_quo == pfs_pkg::VALUE_WIDTH'(1))
                     || (cnt_reg == pfs_pkg::CNT_WIDTH'(pfs_pkg::MAX_RESULTS - 1));
    assign in_bound   = sq_reg <= pfs_pkg::SQ_WIDTH'(n_reg);
    assign tail_prime = n_reg > pfs_pkg::VALUE_WIDTH'(3);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pfs_pkg::ST_IDLE: begin
                if (accept && (s_value > pfs_pkg::VALUE_WIDTH'(1))) begin
                    state_next = pfs_pkg::ST_ISSUE;
                end
            end
            pfs_pkg::ST_ISSUE: begin
                state_next = pfs_pkg::ST_WAIT;
            end
            pfs_pkg::ST_WAIT: begin
                if (div_done) begin
                    state_next = pfs_pkg::ST_CHECK;
                end
            end
            pfs_pkg::ST_CHECK: begin
                if (div_hit) begin
                    if (out_free) begin
                        state_next = hit_last ? pfs_pkg::ST_IDLE : pfs_pkg::ST_ISSUE;
                    end
                end else if (cls_reg == pfs_pkg::DC_TWO || cls_reg == pfs_pkg::DC_LOW) begin
                    state_next = pfs_pkg::ST_ISSUE;
                end else begin
                    state_next = pfs_pkg::ST_TEST;
                end
            end
            pfs_pkg::ST_TEST: begin
                if (in_bound) begin
                    state_next = pfs_pkg::ST_ISSUE;
                end else if (!tail_prime || out_free) begin
                    state_next = pfs_pkg::ST_IDLE;
                end
            end
            default: state_next = pfs_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_ready   = 1'b0;
        div_start = 1'b0;
        load_hit  = 1'b0;
        load_tail = 1'b0;
        unique case (state_reg)
            pfs_pkg::ST_IDLE:  s_ready   = 1'b1;
            pfs_pkg::ST_ISSUE: div_start = 1'b1;
            pfs_pkg::ST_WAIT:  ;
            pfs_pkg::ST_CHECK: load_hit  = div_hit && out_free;
            pfs_pkg::ST_TEST:  load_tail = !in_bound && tail_prime && out_free;
            default:           ;
        endcase
    end

    // datapath
    always_comb begin
        n_next        = n_reg;
        d_next        = d_reg;
        cls_next      = cls_reg;
        sq_next       = sq_reg;
        cnt_next      = cnt_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_factor_next = m_factor_reg;
        m_last_next   = m_last_reg;

        if (accept) begin
            n_next   = s_value;
            d_next   = pfs_pkg::DIVISOR_TWO;
            cls_next = pfs_pkg::DC_TWO;
            cnt_next = '0;
        end

        if (load_hit) begin
            n_next        = div_quo;
            cnt_next      = cnt_reg + pfs_pkg::CNT_WIDTH'(1);
            m_valid_next  = 1'b1;
            m_factor_next = pfs_pkg::VALUE_WIDTH'(d_reg);
            m_last_next   = hit_last;
        end else if (load_tail) begin
            m_valid_next  = 1'b1;
            m_factor_next = n_reg;
            m_last_next   = 1'b1;
        end

        // advance to the next trial divisor
        if (state_reg == pfs_pkg::ST_CHECK && !div_hit) begin
            unique case (cls_reg)
                pfs_pkg::DC_TWO: begin
                    d_next   = pfs_pkg::DIVISOR_THREE;
                    cls_next = pfs_pkg::DC_THREE;
                end
                pfs_pkg::DC_THREE: begin
                    d_next   = pfs_pkg::FIRST_WHEEL;
                    sq_next  = pfs_pkg::FIRST_WHEEL_SQ;
                    cls_next = pfs_pkg::DC_LOW;
                end
                pfs_pkg::DC_LOW: begin
                    d_next   = d_reg + pfs_pkg::DIV_WIDTH'(2);
                    cls_next = pfs_pkg::DC_HIGH;
                end
                pfs_pkg::DC_HIGH: begin
                    d_next   = d_reg + pfs_pkg::DIV_WIDTH'(4);
                    sq_next  = sq_reg + (pfs_pkg::SQ_WIDTH'(d_reg) << 3)
                             + (pfs_pkg::SQ_WIDTH'(d_reg) << 2)
                             + pfs_pkg::SQ_WIDTH'(12);
                    cls_next = pfs_pkg::DC_LOW;
                end
                default: cls_next = pfs_pkg::DC_TWO;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pfs_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        n_reg        <= n_next;
        d_reg        <= d_next;
        cls_reg      <= cls_next;
        sq_reg       <= sq_next;
        cnt_reg      <= cnt_next;
        m_factor_reg <= m_factor_next;
        m_last_reg   <= m_last_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_factor = m_factor_reg;
    assign m_last   = m_last_reg;

    `PFS_ASSERT_NOW(a_done_in_wait, div_done, state_reg == pfs_pkg::ST_WAIT, "done outside wait")
    `PFS_ASSERT_NOW(a_factor_min, m_valid, m_factor >= pfs_pkg::VALUE_WIDTH'(2), "factor below two")
    `PFS_ASSERT_NOW(a_load_free, load_hit || load_tail, out_free, "output overwritten")
    `PFS_ASSERT_NEXT(a_last_idle, load_hit && hit_last, state_reg == pfs_pkg::ST_IDLE, "not idle")

endmodule

/* tb/tb_prime_factor_stream_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_prime_factor_stream_core
// Feeds directed and random numbers to the factorizer, computes each number's
// run of prime factors on acceptance and checks every result transaction
// in order against it, under three mixes of sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_prime_factor_stream_core;

    localparam longint unsigned VALUE_LIMIT = 64'd1 << pfs_pkg::VALUE_WIDTH;
    localparam int RANDOM_PER_STAGE = 26;
    localparam int DRAIN_CYCLES     = 500;
    localparam int CYCLE_LIMIT      = 5000000;
    localparam int REPORT_LIMIT     = 10;

    typedef struct packed {
        logic [pfs_pkg::VALUE_WIDTH-1:0] factor;
        logic                            last;
    } factor_beat_t;

    logic                            aclk    = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    logic [pfs_pkg::VALUE_WIDTH-1:0] s_value = '0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    logic [pfs_pkg::VALUE_WIDTH-1:0] m_factor;
    logic                            m_last;

    logic [pfs_pkg::VALUE_WIDTH-1:0] pending_values[$];
    factor_beat_t                    expected_factors[$];
    int                              send_idle_pct = 0;
    int                              recv_idle_pct = 0;
    int                              error_count   = 0;
    int                              cycle_count   = 0;

    prime_factor_stream_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_value  (s_value),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_factor (m_factor),
        .m_last   (m_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Trial division over 2, 3, then the 6k-1 / 6k+1 wheel; cut off at MAX_RESULTS.
    function automatic void factorize_value(input logic [pfs_pkg::VALUE_WIDTH-1:0] value);
        longint unsigned                 rem;
        longint unsigned                 d;
        logic [pfs_pkg::VALUE_WIDTH-1:0] found[$];
        factor_beat_t                    beat;
        rem = value;
        d   = 2;
        while (rem > 1 && d * d <= rem && found.size() < pfs_pkg::MAX_RESULTS) begin
            if (rem % d == 0) begin
                found.push_back(pfs_pkg::VALUE_WIDTH'(d));
                rem = rem / d;
            end else if (d == 2) begin
                d = 3;
            end else if (d == 3) begin
                d = 5;
            end else if (d % 6 == 5) begin
                d = d + 2;
            end else begin
                d = d + 4;
            end
        end
        if (rem > 1 && found.size() < pfs_pkg::MAX_RESULTS)
            found.push_back(pfs_pkg::VALUE_WIDTH'(rem));
        foreach (found[i]) begin
            beat.factor = found[i];
            beat.last   = (i == found.size() - 1);
            expected_factors.push_back(beat);
        end
    endfunction

    // Mostly products of small numbers, some with a cofactor up to 16 bits.
    function automatic logic [pfs_pkg::VALUE_WIDTH-1:0] random_value();
        longint unsigned v;
        longint unsigned f;
        int              mode;
        mode = $urandom_range(0, 9);
        if (mode == 0)
            return pfs_pkg::VALUE_WIDTH'($urandom_range(0, 3));
        if (mode == 1)
            return pfs_pkg::VALUE_WIDTH'($urandom_range(0, 65535));
        v = 1;
        repeat ($urandom_range(1, 24)) begin
            case ($urandom_range(0, 3))
                0: f = 2;
                1: f = 3;
                2: f = $urandom_range(5, 60);
                default: f = $urandom_range(61, 255);
            endcase
            if (v * f < VALUE_LIMIT)
                v = v * f;
        end
        if (mode < 5) begin
            f = $urandom_range(257, 65535);
            if (v * f < VALUE_LIMIT)
                v = v * f;
        end
        return pfs_pkg::VALUE_WIDTH'(v);
    endfunction

    // Driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_value <= '0;
        end else begin
            if (s_valid && s_ready)
                factorize_value(s_value);
            if (!s_valid || s_ready) begin
                if (pending_values.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_value <= pending_values.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor
    always @(posedge aclk) begin
        factor_beat_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_factors.size() == 0) begin
                    if (error_count < REPORT_LIMIT)
                        $display("unexpected transaction: factor %0d last %0b",
                                 m_factor, m_last);
                    error_count++;
                end else begin
                    want = expected_factors.pop_front();
                    if (m_factor !== want.factor || m_last !== want.last) begin
                        if (error_count < REPORT_LIMIT)
                            $display("mismatch: factor %0d last %0b, expected factor %0d last %0b",
                                     m_factor, m_last, want.factor, want.last);
                        error_count++;
                    end
                end
            end
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int stage;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        for (stage = 0; stage < 3; stage++) begin
            case (stage)
                0: begin
                    send_idle_pct = 13;
                    recv_idle_pct = 81;
                    pending_values = '{31'd0, 31'd1, 31'd2, 31'd3, 31'd4, 31'd5, 31'd6, 31'd7,
                                       31'd25, 31'd35, 31'd49, 31'd121, 31'd143, 31'd169,
                                       31'd65521, 31'd16752649, 31'd1073741824,
                                       31'd1073741825, 31'd1162261467, 31'd1610612736,
                                       31'd2147483646, 31'd2147483647};
                end
                1: begin
                    send_idle_pct = 81;
                    recv_idle_pct = 13;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            repeat (RANDOM_PER_STAGE) pending_values.push_back(random_value());
            // hold the sender until the whole stage has drained
            while (pending_values.size() != 0 || s_valid || expected_factors.size() != 0)
                @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* prime_factor_stream_core.f */
+incdir+sv
sv/pfs_pkg.sv
sv/pfs_div.sv
sv/prime_factor_stream_core.sv
tb/tb_prime_factor_stream_core.sv
